>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/cple_pkg.sv
// Package: opcodes, status codes, sizes and request/result structs of the circular list engine.
`timescale 1ns / 1ps
package cple_pkg;
    localparam int unsigned MAX_CAP = 64;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned CNT_W   = 7;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_POS  = 3'd5,
        OP_DISPLAY  = 3'd6,
        OP_COUNT    = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic signed [31:0] value;
        logic [7:0]  position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic signed [31:0] element;
        logic        element_valid;
        logic        last;
        logic [6:0]  count;
    } t_rsp;
endpackage

>>> sv/cple_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface cple_req_if;
    logic           valid;
    logic           ready;
    cple_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cple_rsp_if;
    logic           valid;
    logic           ready;
    cple_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/circular_positional_list_engine.sv
// Top level: doubly linked circular list engine over slot memories.
//
//  channel  dir  payload                                      accept
//  req      in   opcode, value, position                      valid & ready
//  rsp      out  status, element, element_valid, last, count  valid & ready
//
// One item at a time; req.ready is high only in idle. After an accept the item
// is decoded; a count or a rejected op goes straight to its result, an insert
// takes a free slot, walks to its position if inside the list and links the new
// slot, a delete walks to its position if inside and unlinks, and a display
// sends one element per result. After reset the free stack is refilled with
// req.ready low. A stalled result holds the sequencer in place.
`timescale 1ns / 1ps
module circular_positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cple_req_if.sink   req,
    cple_rsp_if.source rsp
);
    localparam int SW = cple_pkg::SLOT_W;
    localparam int CW = cple_pkg::CNT_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_SLOT = SW'(cple_pkg::MAX_CAP - 1);

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_TAKE  = 10'b0000001000,
        S_WALK  = 10'b0000010000,
        S_LINK  = 10'b0000100000,
        S_LINK2 = 10'b0001000000,
        S_DEL   = 10'b0010000000,
        S_DOUT  = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        K_HEAD = 2'd0,
        K_TAIL = 2'd1,
        K_MID  = 2'd2,
        K_ONLY = 2'd3
    } t_kind;

    t_state              r_state;
    cple_pkg::t_req      r_req;
    logic [SW-1:0]       r_head, r_tail, r_slot, r_cur, r_nxt;
    logic [CW-1:0]       r_cnt, r_top, r_steps;
    cple_pkg::t_status   r_status;
    t_kind               r_kind;
    logic                r_ovalid;
    cple_pkg::t_rsp      r_out;

    // memories
    logic          dat_we, nx_we, pv_we, fs_we;
    logic [SW-1:0] dat_wa, nx_wa, pv_wa, fs_wa, nx_ra, fs_ra, dat_ra, pv_ra;
    logic [31:0]   dat_wd, dat_rd;
    logic [SW-1:0] nx_wd, pv_wd, fs_wd, nx_rd, pv_rd, fs_rd;

    cple_ram #(.WIDTH(32), .DEPTH(cple_pkg::MAX_CAP)) u_dat (
        .i_clk, .i_we(dat_we), .i_waddr(dat_wa), .i_wdata(dat_wd),
        .i_raddr(dat_ra), .o_rdata(dat_rd));
    cple_ram #(.WIDTH(SW), .DEPTH(cple_pkg::MAX_CAP)) u_nx (
        .i_clk, .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    cple_ram #(.WIDTH(SW), .DEPTH(cple_pkg::MAX_CAP)) u_pv (
        .i_clk, .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    cple_ram #(.WIDTH(SW), .DEPTH(cple_pkg::MAX_CAP)) u_fs (
        .i_clk, .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(fs_ra), .o_rdata(fs_rd));

    cple_pkg::t_opcode op;
    logic [7:0]        cnt8;
    logic              ins_pos_bad, del_pos_bad, full, is_ins;
    logic              can_emit, emit;
    cple_pkg::t_rsp    emit_rsp;
    cple_pkg::t_status dec_status;
    t_kind             dec_kind;
    t_state            dec_state;
    logic [SW-1:0]     dec_slot;

    assign op          = cple_pkg::t_opcode'(r_req.opcode);
    assign cnt8        = {1'b0, r_cnt};
    assign ins_pos_bad = (r_req.position == 8'd0) || (r_req.position > cnt8 + 8'd1);
    assign del_pos_bad = (r_req.position == 8'd0) || (r_req.position > cnt8);
    assign full        = (r_cnt >= CAP);
    assign is_ins      = op inside {cple_pkg::OP_INS_HEAD, cple_pkg::OP_INS_TAIL,
                                    cple_pkg::OP_INS_POS};
    assign can_emit    = !r_ovalid || rsp.ready;
    assign emit        = can_emit && (r_state == S_RESP || r_state == S_DOUT);

    assign req.ready = (r_state == S_IDLE);
    assign rsp.valid = r_ovalid;
    assign rsp.data  = r_out;

    // decode of the held item
    always_comb begin
        dec_status = cple_pkg::ST_OK;
        dec_kind   = K_MID;
        dec_state  = S_RESP;
        dec_slot   = r_head;
        unique case (op) inside
            cple_pkg::OP_INS_HEAD, cple_pkg::OP_INS_TAIL, cple_pkg::OP_INS_POS: begin
                if (op == cple_pkg::OP_INS_POS && ins_pos_bad) begin
                    dec_status = cple_pkg::ST_BADPOS;
                end else if (full) begin
                    dec_status = cple_pkg::ST_FULL;
                end else begin
                    dec_state = S_TAKE;
                    if (op == cple_pkg::OP_INS_HEAD ||
                        (op == cple_pkg::OP_INS_POS && r_req.position == 8'd1)) begin
                        dec_kind = K_HEAD;
                    end else if (op == cple_pkg::OP_INS_TAIL ||
                                 r_req.position == cnt8 + 8'd1) begin
                        dec_kind = K_TAIL;
                    end
                end
            end
            cple_pkg::OP_DEL_HEAD, cple_pkg::OP_DEL_TAIL, cple_pkg::OP_DEL_POS: begin
                if (op == cple_pkg::OP_DEL_POS && del_pos_bad) begin
                    dec_status = cple_pkg::ST_BADPOS;
                end else if (r_cnt == '0) begin
                    dec_status = cple_pkg::ST_EMPTY;
                end else begin
                    dec_state = S_DEL;
                    if (r_cnt == 7'd1) begin
                        dec_kind = K_ONLY;
                    end else if (op == cple_pkg::OP_DEL_HEAD ||
                                 (op == cple_pkg::OP_DEL_POS && r_req.position == 8'd1)) begin
                        dec_kind = K_HEAD;
                    end else if (op == cple_pkg::OP_DEL_TAIL || r_req.position == cnt8) begin
                        dec_kind = K_TAIL;
                        dec_slot = r_tail;
                    end else begin
                        dec_state = S_WALK;
                    end
                end
            end
            cple_pkg::OP_DISPLAY: begin
                if (r_cnt != '0) dec_state = S_DOUT;
            end
            cple_pkg::OP_COUNT: ;
        endcase
    end

    // memory ports
    always_comb begin
        dat_we = 1'b0; dat_wa = r_slot; dat_wd = r_req.value; dat_ra = r_cur;
        nx_we = 1'b0; nx_wa = r_slot; nx_wd = r_slot; nx_ra = r_cur;
        pv_we = 1'b0; pv_wa = r_slot; pv_wd = r_slot; pv_ra = r_tail;
        fs_we = 1'b0; fs_wa = r_top[SW-1:0]; fs_wd = r_slot;
        fs_ra = SW'(r_top - 7'd1);
        unique case (r_state)
            S_INIT: begin
                fs_we = 1'b1; fs_wa = r_slot; fs_wd = r_slot;
            end
            S_DEC: begin
                dat_ra = r_head; nx_ra = r_head;
            end
            S_WALK: begin
                nx_ra = nx_rd;
            end
            S_LINK: begin
                dat_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
                if (r_cnt == '0) begin
                    nx_wd = r_slot; pv_wd = r_slot;
                end else if (r_kind == K_MID) begin
                    nx_wd = r_nxt; pv_wd = r_cur;
                end else begin
                    nx_wd = r_head; pv_wd = r_tail;
                end
            end
            S_LINK2: begin
                nx_we = 1'b1; pv_we = 1'b1;
                if (r_kind == K_MID) begin
                    nx_wa = r_cur; pv_wa = r_nxt;
                end else begin
                    nx_wa = r_tail; pv_wa = r_head;
                end
            end
            S_DEL: begin
                fs_we = (r_top < 7'(cple_pkg::MAX_CAP));
                case (r_kind)
                    K_HEAD: begin
                        nx_we = 1'b1; nx_wa = r_tail; nx_wd = nx_rd;
                        pv_we = 1'b1; pv_wa = nx_rd; pv_wd = r_tail;
                    end
                    K_TAIL: begin
                        nx_we = 1'b1; nx_wa = pv_rd; nx_wd = r_head;
                        pv_we = 1'b1; pv_wa = r_head; pv_wd = pv_rd;
                    end
                    K_MID: begin
                        nx_we = 1'b1; nx_wa = r_cur; nx_wd = nx_rd;
                        pv_we = 1'b1; pv_wa = nx_rd; pv_wd = r_cur;
                    end
                    default: ;
                endcase
            end
            S_DOUT: begin
                if (can_emit) begin
                    dat_ra = nx_rd; nx_ra = nx_rd;
                end
            end
            default: ;
        endcase
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_slot <= '0; r_top <= CAP; r_head <= '0;
            r_tail <= '0; r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_slot <= r_slot + SW'(1);
                    if (r_slot == LAST_SLOT) r_state <= S_IDLE;
                end
                S_IDLE: if (req.valid) begin
                    r_req <= req.data;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_status <= dec_status;
                    r_kind <= dec_kind;
                    r_slot <= dec_slot;
                    r_cur <= r_head;
                    r_steps <= (op == cple_pkg::OP_DISPLAY) ? r_cnt
                                                            : CW'(r_req.position - 8'd2);
                    r_state <= dec_state;
                end
                S_TAKE: begin
                    r_slot <= fs_rd;
                    r_top <= r_top - 7'd1;
                    r_state <= (r_kind == K_MID) ? S_WALK : S_LINK;
                end
                S_WALK: begin
                    // nx_rd is the link after r_cur
                    if (r_steps != '0) begin
                        r_cur <= nx_rd; r_steps <= r_steps - 7'd1;
                    end else if (is_ins) begin
                        r_nxt <= nx_rd; r_state <= S_LINK;
                    end else begin
                        r_slot <= nx_rd; r_state <= S_DEL;
                    end
                end
                S_LINK: begin
                    if (r_cnt == '0) begin
                        r_head <= r_slot; r_tail <= r_slot;
                        r_cnt <= r_cnt + 7'd1;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_LINK2;
                    end
                end
                S_LINK2: begin
                    if (r_kind == K_HEAD) r_head <= r_slot;
                    if (r_kind == K_TAIL) r_tail <= r_slot;
                    r_cnt <= r_cnt + 7'd1;
                    r_state <= S_RESP;
                end
                S_DEL: begin
                    r_top <= r_top + 7'd1;
                    r_cnt <= r_cnt - 7'd1;
                    case (r_kind)
                        K_ONLY: begin
                            r_head <= '0; r_tail <= '0;
                        end
                        K_HEAD: r_head <= nx_rd;
                        K_TAIL: r_tail <= pv_rd;
                        default: ;
                    endcase
                    r_state <= S_RESP;
                end
                S_DOUT: if (can_emit) begin
                    r_cur <= nx_rd;
                    r_steps <= r_steps - 7'd1;
                    if (r_steps == 7'd1) r_state <= S_IDLE;
                end
                S_RESP: if (can_emit) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        emit_rsp.status        = r_status;
        emit_rsp.element       = '0;
        emit_rsp.element_valid = 1'b0;
        emit_rsp.last          = 1'b1;
        emit_rsp.count         = r_cnt;
        if (r_state == S_DOUT) begin
            emit_rsp.status        = cple_pkg::ST_OK;
            emit_rsp.element       = dat_rd;
            emit_rsp.element_valid = 1'b1;
            emit_rsp.last          = (r_steps == 7'd1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= emit_rsp;
    end
endmodule

>>> sv/cple_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cple_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/cple_checker.sv
// Port-level checker for the circular list engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cple_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic       rsp_element_valid,
    input logic       rsp_last,
    input logic [6:0] rsp_count
);
    logic elem_out;
    logic ctrl_out;
    assign elem_out = rsp_valid && rsp_element_valid;
    assign ctrl_out = rsp_valid && !rsp_element_valid;

    `CHK_IMPL(a_cnt_range, i_clk, i_rst_n, rsp_valid, rsp_count <= 7'd64, "count over capacity")
    `CHK_IMPL(a_elem_ok, i_clk, i_rst_n, elem_out, rsp_status == cple_pkg::ST_OK, "bad status")
    `CHK_IMPL(a_nonelem_last, i_clk, i_rst_n, ctrl_out, rsp_last, "non-element result not last")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
    `CHK_NEXT(a_busy, i_clk, i_rst_n, req_valid && req_ready, !req_ready, "ready after accept")
endmodule

bind circular_positional_list_engine cple_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.data.status), .rsp_element_valid(rsp.data.element_valid),
    .rsp_last(rsp.data.last), .rsp_count(rsp.data.count)
);
